// ----- design/brfdp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte ring FIFO with delimiter peek.
// Holds op and status codes, register indexes, the control state type and the memory
// control struct. Depends on nothing.
package brfdp_pkg;

    // Input op codes.
    localparam logic [2:0] OP_INSERT_START = 3'd0;
    localparam logic [2:0] OP_INSERT_BYTE  = 3'd1;
    localparam logic [2:0] OP_PEEK         = 3'd2;
    localparam logic [2:0] OP_POP          = 3'd3;
    localparam logic [2:0] OP_PEEK_UNTIL   = 3'd4;
    localparam logic [2:0] OP_CLEAR        = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PARAM_ERR = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_NO_DATA   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_MAX_INSERT = 1'b1;

    // Register widths and reset values.
    localparam int CAP_W = 11;
    localparam int MAX_INS_W = 8;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;
    localparam logic [MAX_INS_W-1:0] MAX_INSERT_RESET = 8'd255;

    // Carriage return, taken as part of a delimiter run.
    localparam logic [7:0] CR_BYTE = 8'h0D;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // Memory access strobes.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ----- design/brfdp_mem.sv -----
`timescale 1ns / 1ps
// Byte store of the ring FIFO: one write port and one registered read port.
// Depends on brfdp_pkg for the memory control struct.
module brfdp_mem
    import brfdp_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write, and registered read: read data appears in the cycle after a strobed read address.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/byte_ring_fifo_with_delimiter_peek_top.sv -----
`timescale 1ns / 1ps
// Byte ring FIFO with delimiter peek, top level. Uses brfdp_pkg and brfdp_mem.
// Single-result ops stay in idle; an item is taken while idle and the output register is free.
// Peek of n bytes: accept, a memory read, then one byte per cycle unless the output stalls.
// Peek-until of n bytes: a scan of n or n+1 reads sets the status, then the bytes are read
// again and emitted; the single memory read port sets the pace.
// Synchronous active-low reset empties the buffer and restores both registers to their defaults.
module byte_ring_fifo_with_delimiter_peek_top
    import brfdp_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int MAX_PEEK = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [2:0]   i_op,
    input  logic [7:0]   i_data_byte,
    input  logic [9:0]   i_length,
    input  logic [7:0]   i_delimiter,
    input  logic         i_clip_mode,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [7:0]   o_out_byte,
    output logic         o_byte_valid,
    output logic         o_last,
    output logic [1:0]   o_status,
    output logic [9:0]   o_used_count,
    output logic [9:0]   o_free_count,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [10:0]  i_cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(MAX_PEEK + 1);

    // State registers.
    t_state                 r_state, n_state;
    logic [CAP_W-1:0]       r_capacity, n_capacity;
    logic [MAX_INS_W-1:0]   r_max_ins, n_max_ins;
    logic [PW-1:0]          r_rp, n_rp;
    logic [PW-1:0]          r_wp, n_wp;
    logic [PW-1:0]          r_pwp, n_pwp;
    logic [7:0]             r_ins_rem, n_ins_rem;
    logic [PW-1:0]          r_p, n_p;
    logic [NW-1:0]          r_n, n_n;
    logic [NW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_bound, n_bound;
    logic                   r_phase, n_phase;
    logic [7:0]             r_delim, n_delim;
    logic [1:0]             r_status, n_status;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_byte, n_out_byte;
    logic                   r_byte_valid, n_byte_valid;
    logic                   r_last, n_last;
    logic [1:0]             r_ostat, n_ostat;
    logic [9:0]             r_used, n_used;
    logic [9:0]             r_free, n_free;

    // Datapath signals.
    logic [CW-1:0]          cap_eff;
    logic [CW-1:0]          used_cur;
    logic [CW-1:0]          used_nx;
    logic [CW-1:0]          free_nx;
    logic [PW-1:0]          p_next;
    logic [PW:0]            p_inc;
    logic [PW:0]            pwp_inc;
    logic [PW-1:0]          pwp_next;
    logic [31:0]            pop_sum;
    logic [31:0]            peek_n;
    logic [31:0]            bound32;
    logic [9:0]             lim_m1;
    logic                   out_free;
    logic                   accept;
    logic                   take;
    logic                   phase_nx;
    logic [NW:0]            n_inc;
    logic                   emit_last;
    t_mem_ctl               mem_ctl;
    logic [PW-1:0]          rd_addr;
    logic [7:0]             rd_data;

    // Capacity in use, held to the range 2 to DEPTH.
    always_comb begin
        if (32'(r_capacity) < 32'd2) begin
            cap_eff = CW'(2);
        end else if (32'(r_capacity) > 32'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(r_capacity);
        end
    end

    // Fill level of the current pointers.
    assign used_cur = (r_wp >= r_rp) ? CW'(r_wp - r_rp)
                    : CW'((CW+1)'(cap_eff) + (CW+1)'(r_wp) - (CW+1)'(r_rp));

    // Fill level after this cycle, reported with each result.
    assign used_nx = (n_wp >= n_rp) ? CW'(n_wp - n_rp)
                   : CW'((CW+1)'(cap_eff) + (CW+1)'(n_wp) - (CW+1)'(n_rp));
    assign free_nx = cap_eff - used_nx - CW'(1);

    // Ring increments.
    assign p_inc    = (PW+1)'(r_p) + (PW+1)'(1);
    assign p_next   = (32'(p_inc) == 32'(cap_eff)) ? '0 : PW'(p_inc);
    assign pwp_inc  = (PW+1)'(r_pwp) + (PW+1)'(1);
    assign pwp_next = (32'(pwp_inc) == 32'(cap_eff)) ? '0 : PW'(pwp_inc);
    assign pop_sum  = 32'(r_rp) + 32'(i_length);

    // Peek-until bound: limit minus one, held to MAX_PEEK and the bytes held.
    assign lim_m1 = (i_length == 10'd0) ? 10'd0 : i_length - 10'd1;
    always_comb begin
        bound32 = 32'(lim_m1);
        if (bound32 > 32'(MAX_PEEK)) begin
            bound32 = 32'(MAX_PEEK);
        end
        if (bound32 > 32'(used_cur)) begin
            bound32 = 32'(used_cur);
        end
    end

    // Peek count after clipping.
    assign peek_n = (32'(i_length) > 32'(used_cur)) ? 32'(used_cur) : 32'(i_length);

    // Scan step on the byte just read.
    assign take     = !r_phase || (rd_data == r_delim) || (rd_data == CR_BYTE);
    assign phase_nx = r_phase || (rd_data == r_delim);
    assign n_inc    = (NW+1)'(r_n) + (NW+1)'(1);
    assign emit_last = ((NW+1)'(r_cnt) + (NW+1)'(1)) == (NW+1)'(r_n);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && (r_state == S_IDLE) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);

    // Sequencer: next state, pointer updates, memory accesses and result loading.
    always_comb begin
        n_state      = r_state;
        n_capacity   = r_capacity;
        n_max_ins    = r_max_ins;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_pwp        = r_pwp;
        n_ins_rem    = r_ins_rem;
        n_p          = r_p;
        n_n          = r_n;
        n_cnt        = r_cnt;
        n_bound      = r_bound;
        n_phase      = r_phase;
        n_delim      = r_delim;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_byte_valid = r_byte_valid;
        n_last       = r_last;
        n_ostat      = r_ostat;
        mem_ctl      = '0;
        rd_addr      = r_p;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Default: one empty result closing the item.
                    n_out_valid  = 1'b1;
                    n_out_byte   = 8'd0;
                    n_byte_valid = 1'b0;
                    n_last       = 1'b1;
                    n_ostat      = ST_OK;
                    if (i_op == OP_INSERT_BYTE) begin
                        if (r_ins_rem == 8'd0) begin
                            n_ostat = ST_PARAM_ERR;
                        end else begin
                            mem_ctl.wr_en = 1'b1;
                            n_pwp     = pwp_next;
                            n_ins_rem = r_ins_rem - 8'd1;
                            if (r_ins_rem == 8'd1) begin
                                n_wp = pwp_next;
                            end
                        end
                    end else if (r_ins_rem != 8'd0) begin
                        n_ostat = ST_PARAM_ERR;
                    end else begin
                        case (i_op)
                            OP_INSERT_START: begin
                                if (32'(i_length) > 32'(r_max_ins)) begin
                                    n_ostat = ST_PARAM_ERR;
                                end else if (32'(cap_eff - used_cur) <= 32'(i_length)) begin
                                    n_ostat = ST_NO_SPACE;
                                end else begin
                                    n_pwp     = r_wp;
                                    n_ins_rem = i_length[7:0];
                                end
                            end
                            OP_PEEK: begin
                                if (32'(i_length) > 32'(used_cur) && !i_clip_mode) begin
                                    n_ostat = ST_NO_DATA;
                                end else if (peek_n > 32'(MAX_PEEK)) begin
                                    n_ostat = ST_PARAM_ERR;
                                end else if (peek_n != 32'd0) begin
                                    n_out_valid = r_out_valid && i_out_stall;
                                    n_p      = r_rp;
                                    n_n      = NW'(peek_n);
                                    n_cnt    = '0;
                                    n_status = ST_OK;
                                    n_state  = S_EMIT_RD;
                                end
                            end
                            OP_POP: begin
                                if (32'(i_length) > 32'(used_cur)) begin
                                    n_ostat = ST_PARAM_ERR;
                                end else if (pop_sum >= 32'(cap_eff)) begin
                                    n_rp = PW'(pop_sum - 32'(cap_eff));
                                end else begin
                                    n_rp = PW'(pop_sum);
                                end
                            end
                            OP_PEEK_UNTIL: begin
                                if (bound32 == 32'd0) begin
                                    n_ostat = ST_NO_DATA;
                                end else begin
                                    n_out_valid = r_out_valid && i_out_stall;
                                    n_p      = r_rp;
                                    n_n      = '0;
                                    n_bound  = NW'(bound32);
                                    n_phase  = 1'b0;
                                    n_delim  = i_delimiter;
                                    n_state  = S_SCAN_RD;
                                end
                            end
                            OP_CLEAR: begin
                                n_rp  = '0;
                                n_wp  = '0;
                                n_pwp = '0;
                            end
                            default: begin
                                n_ostat = ST_PARAM_ERR;
                            end
                        endcase
                    end
                end
            end
            S_SCAN_RD: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = r_p;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (take && (n_inc != (NW+1)'(r_bound))) begin
                    // Keep scanning with the next byte.
                    n_n           = NW'(n_inc);
                    n_phase       = phase_nx;
                    n_p           = p_next;
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = p_next;
                end else begin
                    // Scan done: replay the taken bytes from the read pointer.
                    n_n      = take ? NW'(n_inc) : r_n;
                    n_status = (take ? phase_nx : r_phase) ? ST_OK : ST_NO_DATA;
                    n_p      = r_rp;
                    n_cnt    = '0;
                    n_state  = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = r_p;
                n_state       = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = rd_data;
                    n_byte_valid = 1'b1;
                    n_last       = emit_last;
                    n_ostat      = r_status;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt         = r_cnt + NW'(1);
                        n_p           = p_next;
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = p_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes; a capacity write empties the buffer.
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: begin
                    n_capacity = i_cfg_data;
                    n_rp       = '0;
                    n_wp       = '0;
                    n_pwp      = '0;
                    n_ins_rem  = 8'd0;
                end
                CFG_MAX_INSERT: begin
                    n_max_ins = i_cfg_data[MAX_INS_W-1:0];
                end
                default: begin
                    n_max_ins = r_max_ins;
                end
            endcase
        end

        n_used = 10'(used_nx);
        n_free = 10'(free_nx);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAPACITY_RESET;
            r_max_ins   <= MAX_INSERT_RESET;
            r_rp        <= '0;
            r_wp        <= '0;
            r_pwp       <= '0;
            r_ins_rem   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_capacity  <= n_capacity;
            r_max_ins   <= n_max_ins;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_pwp       <= n_pwp;
            r_ins_rem   <= n_ins_rem;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_n     <= n_n;
        r_cnt   <= n_cnt;
        r_bound <= n_bound;
        r_phase <= n_phase;
        r_delim <= n_delim;
        r_status <= n_status;
        if (n_out_valid && out_free) begin
            r_out_byte   <= n_out_byte;
            r_byte_valid <= n_byte_valid;
            r_last       <= n_last;
            r_ostat      <= n_ostat;
            r_used       <= n_used;
            r_free       <= n_free;
        end
    end

    // Byte store.
    brfdp_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (r_pwp),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_last       = r_last;
    assign o_status     = r_ostat;
    assign o_used_count = r_used;
    assign o_free_count = r_free;

    // Pointers always stay inside the ring in use.
    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_rp) < 32'(cap_eff)) && (32'(r_wp) < 32'(cap_eff))
        && (32'(r_pwp) < 32'(cap_eff)))
        else $error("ring pointer beyond capacity");

    // The store is written only for an open insert.
    a_write_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> (r_state == S_IDLE) && (r_ins_rem != 8'd0))
        else $error("store written without an open insert");

    // The emit counter stays below the byte count and the count within MAX_PEEK.
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_OUT) |-> (r_cnt < r_n) && (32'(r_n) <= 32'(MAX_PEEK)))
        else $error("emit count out of range");

    // A result that does not close its item appears only while bytes are emitted.
    a_non_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_state == S_EMIT_OUT))
        else $error("open result outside byte emission");

endmodule

// ----- verif/byte_ring_fifo_with_delimiter_peek_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_with_delimiter_peek_top.
// Drives op items through a queue-fed driver, predicts every result with an in-bench ring model,
// and checks each result in order. Depends on brfdp_pkg and the top-level RTL.
module byte_ring_fifo_with_delimiter_peek_top_test;
    import brfdp_pkg::*;

    // Op codes the block does not define; they must be rejected.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RING_DEPTH   = 1024;
    localparam int PEEK_MAX     = 64;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [9:0] len;
        logic [7:0] delim;
        logic       clip;
    } t_ring_item;

    typedef struct packed {
        logic [7:0] data_b;
        logic       data_ok;
        logic       last;
        logic [1:0] status;
        logic [9:0] used_n;
        logic [9:0] free_n;
    } t_ring_result;

    // Clock, reset and block inputs, all known from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  op_r = '0;
    logic [7:0]  data_r = '0;
    logic [9:0]  len_r = '0;
    logic [7:0]  delim_r = '0;
    logic        clip_r = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [10:0] cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last;
    logic [1:0]  o_status;
    logic [9:0]  o_used_count;
    logic [9:0]  o_free_count;

    // Ring model state.
    logic [7:0]  ring_mem [RING_DEPTH];
    int unsigned rd_ptr, wr_ptr, pend_ptr, ins_left, cap_reg, max_ins;

    t_ring_item   op_send_q [$];
    t_ring_result ring_resp_q [$];
    t_ring_item   offer;
    logic [7:0]   cur_delim;
    int           items_sent = 0;
    int           bad = 0;
    int           gap_left, burst_left;
    int           stall_left, run_left;
    int           hold_reqs = 0;
    int           hold_served = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    byte_ring_fifo_with_delimiter_peek_top uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (op_r),
        .i_data_byte  (data_r),
        .i_length     (len_r),
        .i_delimiter  (delim_r),
        .i_clip_mode  (clip_r),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_used_count (o_used_count),
        .o_free_count (o_free_count),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    function automatic int unsigned umin(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Slots in use after clamping the capacity register to 2..RING_DEPTH.
    function automatic int unsigned ring_slots();
        if (cap_reg < 2) return 2;
        if (cap_reg > RING_DEPTH) return RING_DEPTH;
        return cap_reg;
    endfunction

    // Committed bytes held.
    function automatic int unsigned ring_fill();
        int unsigned c;
        c = ring_slots();
        return ((wr_ptr % c) + c - (rd_ptr % c)) % c;
    endfunction

    // Queue one expected result; counts reflect the state after the op.
    function automatic void ring_resp(input logic [7:0] b, input logic v, input logic l,
                                      input logic [1:0] st);
        t_ring_result r;
        int unsigned u;
        u = ring_fill();
        r.data_b  = b;
        r.data_ok = v;
        r.last    = l;
        r.status  = st;
        r.used_n  = u[9:0];
        r.free_n  = 10'(ring_slots() - u - 1);
        ring_resp_q.push_back(r);
    endfunction

    // Apply one accepted item to the ring model and queue its results.
    function automatic void ring_apply_op(input t_ring_item it);
        int unsigned c, u, n, lim, p, k;
        logic found;
        logic [7:0] scan [PEEK_MAX];
        c = ring_slots();
        u = ring_fill();
        found = 1'b0;
        if (it.op == OP_INSERT_BYTE) begin
            if (ins_left == 0) begin
                ring_resp(8'h00, 1'b0, 1'b1, ST_PARAM_ERR);
            end else begin
                ring_mem[pend_ptr] = it.data;
                pend_ptr = (pend_ptr + 1) % c;
                ins_left--;
                // The message becomes visible only with its last byte.
                if (ins_left == 0) wr_ptr = pend_ptr;
                ring_resp(8'h00, 1'b0, 1'b1, ST_OK);
            end
        end else if (ins_left != 0 || it.op > OP_CLEAR) begin
            ring_resp(8'h00, 1'b0, 1'b1, ST_PARAM_ERR);
        end else begin
            case (it.op)
                OP_INSERT_START: begin
                    if (it.len > max_ins) begin
                        ring_resp(8'h00, 1'b0, 1'b1, ST_PARAM_ERR);
                    end else if (c - u <= it.len) begin
                        ring_resp(8'h00, 1'b0, 1'b1, ST_NO_SPACE);
                    end else begin
                        pend_ptr = wr_ptr;
                        ins_left = it.len;
                        ring_resp(8'h00, 1'b0, 1'b1, ST_OK);
                    end
                end
                OP_PEEK: begin
                    n = it.len;
                    if (n > u && !it.clip) begin
                        ring_resp(8'h00, 1'b0, 1'b1, ST_NO_DATA);
                    end else begin
                        if (n > u) n = u;
                        if (n > PEEK_MAX) begin
                            ring_resp(8'h00, 1'b0, 1'b1, ST_PARAM_ERR);
                        end else if (n == 0) begin
                            ring_resp(8'h00, 1'b0, 1'b1, ST_OK);
                        end else begin
                            p = rd_ptr;
                            for (k = 0; k < n; k++) begin
                                ring_resp(ring_mem[p], 1'b1, k + 1 == n, ST_OK);
                                p = (p + 1) % c;
                            end
                        end
                    end
                end
                OP_POP: begin
                    if (it.len > u) begin
                        ring_resp(8'h00, 1'b0, 1'b1, ST_PARAM_ERR);
                    end else begin
                        rd_ptr = (rd_ptr + it.len) % c;
                        ring_resp(8'h00, 1'b0, 1'b1, ST_OK);
                    end
                end
                OP_PEEK_UNTIL: begin
                    lim = (it.len == 0) ? 0 : it.len - 1;
                    lim = umin(umin(lim, PEEK_MAX), u);
                    p = rd_ptr;
                    n = 0;
                    // Bytes up to the delimiter, then the run of delimiter or CR bytes.
                    while (n < lim && ring_mem[p] != it.delim) begin
                        scan[n] = ring_mem[p];
                        n++;
                        p = (p + 1) % c;
                    end
                    while (n < lim && (ring_mem[p] == it.delim || ring_mem[p] == CR_BYTE)) begin
                        scan[n] = ring_mem[p];
                        n++;
                        p = (p + 1) % c;
                        found = 1'b1;
                    end
                    if (n == 0) begin
                        ring_resp(8'h00, 1'b0, 1'b1, found ? ST_OK : ST_NO_DATA);
                    end else begin
                        for (k = 0; k < n; k++)
                            ring_resp(scan[k], 1'b1, k + 1 == n, found ? ST_OK : ST_NO_DATA);
                    end
                end
                default: begin
                    // Clear.
                    rd_ptr = 0;
                    wr_ptr = 0;
                    pend_ptr = 0;
                    ring_resp(8'h00, 1'b0, 1'b1, ST_OK);
                end
            endcase
        end
    endfunction

    // Item driver: offers queued items, holds each until accepted, idles at random.
    always @(posedge clk) begin : op_driver
        logic took;
        int r;
        took = in_valid && !o_in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (took) begin
                ring_apply_op(offer);
                // Pick the idle time before the next item.
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 8) burst_left = $urandom_range(8, 40);
                    if (r < 50) gap_left = 0;
                    else if (r < 80) gap_left = $urandom_range(1, 2);
                    else if (r < 95) gap_left = $urandom_range(3, 8);
                    else gap_left = $urandom_range(15, 50);
                end
            end
            if (!in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (op_send_q.size() != 0) begin
                    offer = op_send_q.pop_front();
                    op_r     <= offer.op;
                    data_r   <= offer.data;
                    len_r    <= offer.len;
                    delim_r  <= offer.delim;
                    clip_r   <= offer.clip;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every accepted result and drives the receiver stall.
    always @(posedge clk) begin : resp_check
        t_ring_result want, got;
        int r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            run_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got.data_b  = o_out_byte;
                got.data_ok = o_byte_valid;
                got.last    = o_last;
                got.status  = o_status;
                got.used_n  = o_used_count;
                got.free_n  = o_free_count;
                if (ring_resp_q.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected result: byte %02h valid %0d last %0d status %0d",
                                 got.data_b, got.data_ok, got.last, got.status);
                end else begin
                    want = ring_resp_q.pop_front();
                    if (got !== want) begin
                        bad++;
                        if (bad <= 10)
                            $display({"mismatch: expected byte %02h valid %0d last %0d ",
                                      "status %0d used %0d free %0d, got byte %02h valid %0d ",
                                      "last %0d status %0d used %0d free %0d"},
                                     want.data_b, want.data_ok, want.last, want.status,
                                     want.used_n, want.free_n, got.data_b, got.data_ok,
                                     got.last, got.status, got.used_n, got.free_n);
                    end
                end
            end
            // A requested long hold overrides the random stall pattern.
            if (hold_served != hold_reqs) begin
                hold_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    run_left = $urandom_range(10, 50);
                    out_stall <= 1'b0;
                end else if (r < 55) begin
                    out_stall <= 1'b0;
                end else if (r < 85) begin
                    stall_left = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end else if (r < 97) begin
                    stall_left = $urandom_range(3, 9);
                    out_stall <= 1'b1;
                end else begin
                    stall_left = $urandom_range(19, 59);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("byte_ring_fifo_with_delimiter_peek_top verification failed");
        $finish;
    end

    function automatic void add_item(input int unsigned op, input int unsigned data,
                                     input int unsigned len, input int unsigned delim,
                                     input int unsigned clip);
        t_ring_item it;
        it.op    = 3'(op);
        it.data  = 8'(data);
        it.len   = 10'(len);
        it.delim = 8'(delim);
        it.clip  = 1'(clip);
        op_send_q.push_back(it);
        items_sent++;
    endfunction

    // Message content leans toward delimiter and CR bytes so scans find runs.
    function automatic logic [7:0] msg_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return cur_delim;
        if (r < 25) return CR_BYTE;
        return 8'($urandom);
    endfunction

    // Any op other than insert byte, with random fields.
    function automatic void add_stray();
        int unsigned op;
        op = $urandom_range(0, 7);
        if (op == OP_INSERT_BYTE) op = OP_CLEAR;
        add_item(op, $urandom, $urandom_range(0, 1023), $urandom, $urandom);
    endfunction

    task automatic wait_drained();
        while (op_send_q.size() != 0 || in_valid) @(negedge clk);
    endtask

    task automatic wait_results();
        wait_drained();
        while (ring_resp_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        if (idx == CFG_CAPACITY) begin
            // A capacity write empties the ring and drops any open message.
            cap_reg = val;
            rd_ptr = 0;
            wr_ptr = 0;
            pend_ptr = 0;
            ins_left = 0;
        end else begin
            max_ins = val[7:0];
        end
    endtask

    // Insert message: mostly fitting lengths, some oversize, some cut short or interrupted.
    task automatic gen_insert();
        int unsigned room, lim, len, nsend, cut, k, r, stray_at;
        room = ring_slots() - ring_fill() - 1;
        lim = umin(max_ins, room);
        r = $urandom_range(0, 99);
        if (r < 82) begin
            r = $urandom_range(0, 99);
            if (lim == 0) len = 0;
            else if (r < 70) len = $urandom_range(1, umin(lim, 12));
            else if (r < 95) len = $urandom_range(1, umin(lim, 48));
            else len = $urandom_range(1, lim);
            nsend = len;
        end else if (r < 92) begin
            len = umin($urandom_range(0, 1) ? max_ins + 1 : room + 1, 1023);
            nsend = $urandom_range(0, 2);
        end else begin
            len = $urandom_range(0, 1023);
            nsend = umin(len, $urandom_range(0, 3));
        end
        add_item(OP_INSERT_START, $urandom, len, $urandom, $urandom);
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, nsend) : nsend;
        stray_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, cut) : cut + 1;
        for (k = 0; k < cut; k++) begin
            if (k == stray_at) add_stray();
            add_item(OP_INSERT_BYTE, msg_byte(), $urandom, $urandom, $urandom);
        end
    endtask

    // Finish a message left open, sometimes after one rejected op.
    task automatic finish_insert();
        int unsigned n, k;
        n = ins_left;
        if ($urandom_range(0, 99) < 15) add_stray();
        for (k = 0; k < n; k++)
            add_item(OP_INSERT_BYTE, msg_byte(), $urandom, $urandom, $urandom);
    endtask

    task automatic gen_peek();
        int unsigned u, len, r;
        u = ring_fill();
        r = $urandom_range(0, 99);
        if (r < 10 || u == 0) len = (r < 50) ? 0 : $urandom_range(0, 3);
        else if (r < 55) len = $urandom_range(1, umin(u, PEEK_MAX));
        else if (r < 65) len = u;
        else if (r < 75) len = umin(u + 1, 1023);
        else if (r < 85) len = $urandom_range(PEEK_MAX + 1, PEEK_MAX + 16);
        else len = $urandom_range(0, 1023);
        add_item(OP_PEEK, $urandom, len, $urandom, $urandom);
    endtask

    task automatic gen_pop();
        int unsigned u, len, r;
        u = ring_fill();
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, umin(u, 8));
        else if (r < 80) len = u;
        else if (r < 92) len = umin(u + 1, 1023);
        else len = $urandom_range(0, 1023);
        add_item(OP_POP, $urandom, len, $urandom, $urandom);
    endtask

    task automatic gen_until();
        int unsigned len, r;
        logic [7:0] d;
        r = $urandom_range(0, 99);
        if (r < 10) len = $urandom_range(0, 2);
        else if (r < 85) len = $urandom_range(2, PEEK_MAX + 2);
        else len = $urandom_range(PEEK_MAX + 2, 1023);
        r = $urandom_range(0, 99);
        if (r < 70) d = cur_delim;
        else if (r < 80) d = CR_BYTE;
        else d = 8'($urandom);
        add_item(OP_PEEK_UNTIL, $urandom, len, d, $urandom);
    endtask

    // One configuration setting followed by random traffic.
    task automatic run_phase(input logic [10:0] cap, input logic [7:0] mx, input int budget,
                             input bit squeeze);
        int start, r, k;
        wait_results();
        repeat (4) @(negedge clk);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_MAX_INSERT, mx);
        case ($urandom_range(0, 4))
            0: cur_delim = 8'h3B;
            1: cur_delim = 8'h0A;
            2: cur_delim = CR_BYTE;
            3: cur_delim = 8'h00;
            default: cur_delim = 8'($urandom);
        endcase
        if (squeeze) begin
            // The receiver holds off while a long message and peeks keep coming,
            // so the block backs up and stalls its input.
            hold_reqs++;
            add_item(OP_INSERT_START, 0, 100, 0, 0);
            for (k = 0; k < 100; k++)
                add_item(OP_INSERT_BYTE, msg_byte(), $urandom, $urandom, $urandom);
            add_item(OP_PEEK, 0, PEEK_MAX, 0, 0);
            add_item(OP_PEEK, 0, PEEK_MAX + 6, 0, 1);
            add_item(OP_PEEK_UNTIL, 0, PEEK_MAX + 2, cur_delim, 0);
        end
        start = items_sent;
        while (items_sent - start < budget) begin
            wait_drained();
            r = $urandom_range(0, 99);
            if (ins_left != 0) finish_insert();
            else if (r < 34) gen_insert();
            else if (r < 54) gen_peek();
            else if (r < 68) gen_pop();
            else if (r < 87) gen_until();
            else if (r < 91) add_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (r < 97)
                add_item($urandom_range(0, 7), $urandom, $urandom_range(0, 1023), $urandom,
                         $urandom);
            else begin
                // Sender pause until every pending result is back.
                wait_results();
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
        end
    endtask

    initial begin
        rd_ptr = 0;
        wr_ptr = 0;
        pend_ptr = 0;
        ins_left = 0;
        cap_reg = CAPACITY_RESET;
        max_ins = MAX_INSERT_RESET;
        cur_delim = 8'h3B;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty buffer cases, then one message with a delimiter run.
        add_item(OP_PEEK, 0, 0, 0, 0);
        add_item(OP_PEEK, 0, 1, 0, 0);
        add_item(OP_POP, 0, 1, 0, 0);
        add_item(OP_INSERT_BYTE, 8'hFF, 0, 0, 0);
        add_item(OP_PEEK_UNTIL, 0, 0, 8'h3B, 0);
        add_item(OP_INSERT_START, 0, 10'h3FF, 0, 0);
        add_item(OP_INSERT_START, 0, 0, 0, 0);
        add_item(OP_INSERT_START, 0, 6, 0, 0);
        add_item(OP_INSERT_BYTE, 8'h41, 0, 0, 0);
        add_item(OP_INSERT_BYTE, 8'h00, 0, 0, 0);
        add_item(OP_CLEAR, 0, 0, 0, 0);
        add_item(OP_INSERT_BYTE, 8'h3B, 0, 0, 0);
        add_item(OP_INSERT_BYTE, CR_BYTE, 0, 0, 0);
        add_item(OP_INSERT_BYTE, 8'h3B, 0, 0, 0);
        add_item(OP_INSERT_BYTE, 8'hFF, 0, 0, 0);
        add_item(OP_PEEK, 0, 6, 0, 0);
        add_item(OP_PEEK_UNTIL, 0, 10, 8'h3B, 0);
        add_item(OP_PEEK_UNTIL, 0, 3, 8'h3B, 0);
        add_item(OP_PEEK_UNTIL, 0, 10'h3FF, 8'h7E, 1);
        add_item(OP_PEEK, 0, PEEK_MAX + 1, 0, 1);
        add_item(OP_PEEK, 0, PEEK_MAX + 1, 0, 0);
        add_item(OP_SPARE_7, 8'hFF, 10'h3FF, 8'hFF, 1);
        add_item(OP_SPARE_6, 0, 0, 0, 0);
        add_item(OP_POP, 0, 7, 0, 0);
        add_item(OP_POP, 0, 6, 0, 0);
        add_item(OP_CLEAR, 0, 0, 0, 0);

        // Settings from the largest ring down to the clamped minimum and back.
        run_phase(11'd1024, 8'd255, 70, 1'b0);
        run_phase(11'd37, 8'd20, 70, 1'b0);
        run_phase(11'd2, 8'd1, 35, 1'b0);
        run_phase(11'd0, 8'd0, 20, 1'b0);
        run_phase(11'd2047, 8'd255, 30, 1'b1);
        run_phase(11'd300, 8'd100, 80, 1'b0);
        run_phase(11'd5, 8'd255, 40, 1'b0);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ring_resp_q.size() != 0)
            $display("%0d expected results never arrived", ring_resp_q.size());
        if (bad == 0 && ring_resp_q.size() == 0) begin
            $display("byte_ring_fifo_with_delimiter_peek_top verification clean");
        end else begin
            $display("byte_ring_fifo_with_delimiter_peek_top verification failed");
        end
        $finish;
    end

endmodule
